### sv/gtw_pkg.sv
`default_nettype none

package gtw_pkg;

   // line store depth default and fixed field widths
   localparam int LINE_MAX_DEFAULT = 40;
   localparam int CHAR_W           = 8;
   localparam int POS_W            = 7;
   localparam int ROW_W            = 8;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 8;

   // character codes
   localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
   localparam logic [CHAR_W-1:0] NUL_CODE   = 8'd0;

   // register reset values
   localparam logic [5:0] START_COL_RESET    = 6'd0;
   localparam logic [7:0] START_ROW_RESET    = 8'd0;
   localparam logic [7:0] WRAP_WIDTH_RESET   = 8'd40;
   localparam logic [7:0] ROW_BUDGET_RESET   = 8'd28;
   localparam logic [7:0] LINE_SPACING_RESET = 8'd1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_COL    = 3'd0,
      CSR_START_ROW    = 3'd1,
      CSR_WRAP_WIDTH   = 3'd2,
      CSR_ROW_BUDGET   = 3'd3,
      CSR_LINE_SPACING = 3'd4,
      CSR_PALETTE_SEL  = 3'd5
   } csr_index_type;

   // one tile placement handed from the sequencer to the output stage
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [ROW_W-1:0]  row;
      logic              last;
      logic [7:0]        lines;
      logic              done;
   } tile_cmd_type;

endpackage

`default_nettype wire

### sv/gtw_ram.sv
`default_nettype none

module gtw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/gtw_tile.sv
`default_nettype none

module gtw_tile (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire gtw_pkg::tile_cmd_type   cmd,
   input  wire logic [7:0]              rd_data,
   input  wire logic [5:0]              start_col,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_char_code,
   output logic [6:0]                   rsp_tile_col,
   output logic [7:0]                   rsp_tile_row,
   output logic                         rsp_line_end,
   output logic [7:0]                   rsp_lines_drawn,
   output logic                         rsp_layout_done
);

   logic       valid_ff;
   logic [7:0] char_ff;
   logic [6:0] col_ff;
   logic [7:0] row_ff;
   logic       last_ff;
   logic [7:0] lines_ff;
   logic       done_ff;

   // output register, held while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         char_ff  <= rd_data;
         col_ff   <= 7'(start_col) + cmd.pos;
         row_ff   <= cmd.row;
         last_ff  <= cmd.last;
         lines_ff <= cmd.lines;
         done_ff  <= cmd.done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_tile_col    = col_ff;
   assign rsp_tile_row    = row_ff;
   assign rsp_line_end    = last_ff;
   assign rsp_lines_drawn = lines_ff;
   assign rsp_layout_done = done_ff;

endmodule

`default_nettype wire

### sv/greedy_text_word_wrap_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_kind, req_char_in
// rsp     | out       | rsp_valid/rsp_stall  | char, col, row, line_end, lines, done
// csr     | in        | csr_we               | csr_index, csr_wdata
//
// each tile of a finished line goes through a line store read, a wait until the output
// register is empty, and an output load
// a carried-over word moves down one remaining character at a time, each read and then
// written, and a final step writes the overflowing character, through the single line store port pair
// synchronous active-high reset clears control state; the line store is not cleared
// a stalled tile holds the output register and the sequencer waits on it

`default_nettype none

module greedy_text_word_wrap_core #(
   parameter int LINE_MAX = gtw_pkg::LINE_MAX_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_char_code,
   output logic [6:0]      rsp_tile_col,
   output logic [7:0]      rsp_tile_row,
   output logic            rsp_line_end,
   output logic [7:0]      rsp_lines_drawn,
   output logic            rsp_layout_done,
   input  wire logic       csr_we,
   input  wire logic [gtw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gtw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FW = $clog2(LINE_MAX + 1);
   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EMIT_RD, ST_EMIT_LD, ST_SHIFT_RD, ST_SHIFT_CHK, ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      AFT_NONE, AFT_SHIFT, AFT_PUT
   } after_type;

   // configuration
   logic [5:0] start_col_ff;
   logic [7:0] start_row_ff;
   logic [7:0] wrap_width_ff;
   logic [7:0] row_budget_ff;
   logic [7:0] line_spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_col_ff    <= gtw_pkg::START_COL_RESET;
         start_row_ff    <= gtw_pkg::START_ROW_RESET;
         wrap_width_ff   <= gtw_pkg::WRAP_WIDTH_RESET;
         row_budget_ff   <= gtw_pkg::ROW_BUDGET_RESET;
         line_spacing_ff <= gtw_pkg::LINE_SPACING_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gtw_pkg::CSR_START_COL:    start_col_ff    <= csr_wdata[5:0];
            gtw_pkg::CSR_START_ROW:    start_row_ff    <= csr_wdata;
            gtw_pkg::CSR_WRAP_WIDTH:   wrap_width_ff   <= csr_wdata;
            gtw_pkg::CSR_ROW_BUDGET:   row_budget_ff   <= csr_wdata;
            gtw_pkg::CSR_LINE_SPACING: line_spacing_ff <= csr_wdata;
            // palette has no effect on any tile field
            gtw_pkg::CSR_PALETTE_SEL:  ;
            default:                   ;
         endcase
      end
   end

   // sequencer state
   state_type    state_ff, state_in;
   after_type    after_ff, after_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] brk_len_ff, brk_len_in;
   logic          brk_seen_ff, brk_seen_in;
   logic [7:0]    rows_ff, rows_in;
   logic [7:0]    lines_ff, lines_in;
   logic          fin_ff, fin_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [FW-1:0] dst_ff, dst_in;
   logic [FW-1:0] emit_n_ff, emit_n_in;
   logic [7:0]    line_row_ff, line_row_in;
   logic          line_done_ff, line_done_in;
   logic          skip_ff, skip_in;
   logic [7:0]    char_ff, char_in;

   // line store ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   logic                  tile_load;
   gtw_pkg::tile_cmd_type tile_cmd;

   // decode of the incoming character
   logic [7:0]    width_clip, width_eff, spacing_eff;
   logic [8:0]    row_sum;
   logic          accept, is_end, is_space, line_full, has_break;
   logic          wants_emit, do_emit, fin_emit, budget_out;
   logic [FW-1:0] emit_n;

   always_comb begin
      width_clip  = (wrap_width_ff > 8'(LINE_MAX)) ? 8'(LINE_MAX) : wrap_width_ff;
      width_eff   = (width_clip == 8'd0) ? 8'd1 : width_clip;
      spacing_eff = (line_spacing_ff == 8'd0) ? 8'd1 : line_spacing_ff;
      row_sum     = {1'b0, rows_ff} + {1'b0, spacing_eff};
      accept      = req_valid && (state_ff == ST_IDLE);
      is_end      = req_kind || (req_char_in == gtw_pkg::NUL_CODE);
      is_space    = (req_char_in == gtw_pkg::SPACE_CODE);
      line_full   = !(8'(fill_ff) < width_eff);
      has_break   = brk_seen_ff && (brk_len_ff < fill_ff);
      emit_n      = (!is_end && line_full && !is_space && has_break) ? brk_len_ff : fill_ff;
      wants_emit  = is_end || line_full;
      budget_out  = (rows_ff >= row_budget_ff);
      do_emit     = wants_emit && (emit_n != '0) && !budget_out;
      fin_emit    = wants_emit && (emit_n != '0) &&
                    (budget_out || (row_sum >= {1'b0, row_budget_ff}));
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      fill_in      = fill_ff;
      brk_len_in   = brk_len_ff;
      brk_seen_in  = brk_seen_ff;
      rows_in      = rows_ff;
      lines_in     = lines_ff;
      fin_in       = fin_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      emit_n_in    = emit_n_ff;
      line_row_in  = line_row_ff;
      line_done_in = line_done_ff;
      skip_in      = skip_ff;
      char_in      = char_ff;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[AW-1:0];
      ram_wdata    = req_char_in;
      tile_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !fin_ff) begin
               char_in  = req_char_in;
               after_in = AFT_NONE;
               // start a line emission
               if (do_emit) begin
                  lines_in     = lines_ff + 8'd1;
                  rows_in      = row_sum[7:0];
                  line_row_in  = start_row_ff + rows_ff;
                  line_done_in = (row_sum >= {1'b0, row_budget_ff});
                  emit_n_in    = emit_n;
                  idx_in       = '0;
                  state_in     = ST_EMIT_RD;
               end
               if (fin_emit) begin
                  fin_in = 1'b1;
               end
               // what happens to the line store
               if (is_end) begin
                  fin_in      = 1'b1;
                  fill_in     = '0;
                  brk_len_in  = '0;
                  brk_seen_in = 1'b0;
               end else if (!line_full) begin
                  if (!(is_space && fill_ff == '0)) begin
                     ram_we  = 1'b1;
                     fill_in = fill_ff + FW'(1);
                     if (is_space) begin
                        brk_len_in  = fill_ff;
                        brk_seen_in = 1'b1;
                     end
                  end
               end else if (is_space || (has_break && fin_emit)) begin
                  fill_in     = '0;
                  brk_len_in  = '0;
                  brk_seen_in = 1'b0;
               end else if (has_break) begin
                  // remainder after the break moves down once the line is out
                  after_in = AFT_SHIFT;
               end else begin
                  fill_in     = '0;
                  brk_len_in  = '0;
                  brk_seen_in = 1'b0;
                  if (!fin_emit) begin
                     after_in = AFT_PUT;
                     dst_in   = '0;
                  end
               end
            end
         end

         ST_EMIT_RD: begin
            if (!rsp_valid) begin
               state_in = ST_EMIT_LD;
            end
         end

         ST_EMIT_LD: begin
            tile_load = 1'b1;
            if (idx_ff + FW'(1) == emit_n_ff) begin
               unique case (after_ff)
                  AFT_SHIFT: begin
                     idx_in   = brk_len_ff;
                     dst_in   = '0;
                     skip_in  = 1'b1;
                     state_in = ST_SHIFT_RD;
                  end
                  AFT_PUT:  state_in = ST_PUT;
                  AFT_NONE: state_in = ST_IDLE;
                  default:  state_in = ST_IDLE;
               endcase
            end else begin
               idx_in   = idx_ff + FW'(1);
               state_in = ST_EMIT_RD;
            end
         end

         ST_SHIFT_RD: begin
            if ((idx_ff < fill_ff) && (dst_ff < FW'(LINE_MAX - 1))) begin
               state_in = ST_SHIFT_CHK;
            end else begin
               state_in = ST_PUT;
            end
         end

         ST_SHIFT_CHK: begin
            // leading spaces of the carried word are dropped
            idx_in   = idx_ff + FW'(1);
            state_in = ST_SHIFT_RD;
            if (!(skip_ff && ram_rdata == gtw_pkg::SPACE_CODE)) begin
               ram_we    = 1'b1;
               ram_waddr = dst_ff[AW-1:0];
               ram_wdata = ram_rdata;
               dst_in    = dst_ff + FW'(1);
               skip_in   = 1'b0;
            end
         end

         ST_PUT: begin
            // the character that overflowed opens the new line
            ram_we      = 1'b1;
            ram_waddr   = dst_ff[AW-1:0];
            ram_wdata   = char_ff;
            fill_in     = dst_ff + FW'(1);
            brk_len_in  = '0;
            brk_seen_in = 1'b0;
            state_in    = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         after_ff    <= AFT_NONE;
         fill_ff     <= '0;
         brk_len_ff  <= '0;
         brk_seen_ff <= 1'b0;
         rows_ff     <= '0;
         lines_ff    <= '0;
         fin_ff      <= 1'b0;
         idx_ff      <= '0;
         dst_ff      <= '0;
         skip_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         after_ff    <= after_in;
         fill_ff     <= fill_in;
         brk_len_ff  <= brk_len_in;
         brk_seen_ff <= brk_seen_in;
         rows_ff     <= rows_in;
         lines_ff    <= lines_in;
         fin_ff      <= fin_in;
         idx_ff      <= idx_in;
         dst_ff      <= dst_in;
         skip_ff     <= skip_in;
      end
      emit_n_ff    <= emit_n_in;
      line_row_ff  <= line_row_in;
      line_done_ff <= line_done_in;
      char_ff      <= char_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

   // tile fields for the character being read
   always_comb begin
      tile_cmd.pos   = 7'(idx_ff);
      tile_cmd.row   = line_row_ff;
      tile_cmd.last  = (idx_ff + FW'(1) == emit_n_ff);
      tile_cmd.lines = lines_ff;
      tile_cmd.done  = line_done_ff;
   end

   gtw_ram #(
      .WIDTH (gtw_pkg::CHAR_W),
      .DEPTH (LINE_MAX)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   gtw_tile u_tile (
      .clock           (clock),
      .reset           (reset),
      .load            (tile_load),
      .cmd             (tile_cmd),
      .rd_data         (ram_rdata),
      .start_col       (start_col_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_char_code   (rsp_char_code),
      .rsp_tile_col    (rsp_tile_col),
      .rsp_tile_row    (rsp_tile_row),
      .rsp_line_end    (rsp_line_end),
      .rsp_lines_drawn (rsp_lines_drawn),
      .rsp_layout_done (rsp_layout_done)
   );

endmodule

`default_nettype wire
